// File: design/assert_macros.svh
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define AST_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/swft_pkg.sv
package swft_pkg;

  localparam int RX_W    = 8;
  localparam int LIDX_W  = 5;
  localparam int POS_W   = 5;
  localparam int FS_W    = 6;
  localparam int CMP_W   = 7;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CMP_W-1:0] SYNC_LEN = 7'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd2;

  localparam logic [FS_W-1:0] FRAME_SIZE_RST  = 6'd8;
  localparam logic [RX_W-1:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [RX_W-1:0] SYNC_SECOND_RST = 8'd85;

  typedef enum logic [1:0] {
    REQ_RX    = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    LINK_IDLE    = 2'd0,
    LINK_SYNCING = 2'd1,
    LINK_XCVR    = 2'd2
  } link_state_t;

  typedef struct packed {
    logic              accepted;
    logic [POS_W-1:0]  byte_position;
    logic [RX_W-1:0]   data_byte;
    logic              frame_end;
    link_state_t       link_state;
    logic [CNT_W-1:0]  frames_received;
    logic [CNT_W-1:0]  bytes_lost_syncing;
    logic [CNT_W-1:0]  partial_frame_errors;
  } res_t;

endpackage

// File: design/swft_if.sv
interface swft_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [swft_pkg::RX_W-1:0]    rx_byte;
  logic [swft_pkg::LIDX_W-1:0]  load_index;
  logic [swft_pkg::RX_W-1:0]    load_value;

  modport source (output valid, req_type, rx_byte, load_index, load_value, input ready);
  modport sink (input valid, req_type, rx_byte, load_index, load_value, output ready);
endinterface

interface swft_out_if;
  logic                         valid;
  logic                         ready;
  logic [swft_pkg::RX_W-1:0]    tx_byte;
  logic                         accepted;
  logic [swft_pkg::POS_W-1:0]   byte_position;
  logic [swft_pkg::RX_W-1:0]    data_byte;
  logic                         frame_end;
  logic [1:0]                   link_state;
  logic [swft_pkg::CNT_W-1:0]   frames_received;
  logic [swft_pkg::CNT_W-1:0]   bytes_lost_syncing;
  logic [swft_pkg::CNT_W-1:0]   partial_frame_errors;

  modport source (output valid, tx_byte, accepted, byte_position, data_byte, frame_end,
                  link_state, frames_received, bytes_lost_syncing, partial_frame_errors,
                  input ready);
  modport sink (input valid, tx_byte, accepted, byte_position, data_byte, frame_end,
                link_state, frames_received, bytes_lost_syncing, partial_frame_errors,
                output ready);
endinterface

interface swft_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swft_pkg::CFG_IDX_W-1:0]  index;
  logic [swft_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/sync_word_frame_transceiver.sv
// Channel   Dir  Transaction content
// cfg_ch    in   register index, write data (frame_size, sync_first, sync_second)
// in_ch     in   req_type, rx_byte, load_index, load_value
// out_ch    out  tx_byte, status flags, position, echo, three counters
//
// One transaction per cycle on in_ch while in_ch.ready is high; a received byte is read
// into the read stage at its accepting edge, then moves to the output register for out_ch.
// Loads and clears give no result; cfg_ch is always ready.
// rst_n is synchronous; no clearing pass, per-entry flags mark zeroed frames.
// in_ch.ready drops only while both the read stage and the output register
// hold results and out_ch.ready is low.
module sync_word_frame_transceiver #(
  parameter int MAX_FRAME = 32
) (
  input logic          clk,
  input logic          rst_n,
  swft_cfg_if.sink     cfg_ch,
  swft_in_if.sink      in_ch,
  swft_out_if.source   out_ch
);

  localparam int IDXW  = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
  localparam int DEPTH = 2 << IDXW;
  localparam logic [swft_pkg::CMP_W-1:0] MAX_C = swft_pkg::CMP_W'(MAX_FRAME);

  logic [swft_pkg::FS_W-1:0]  frame_size_r;
  logic [swft_pkg::RX_W-1:0]  sync_first_r;
  logic [swft_pkg::RX_W-1:0]  sync_second_r;

  logic [IDXW-1:0]             wp_r, wp_nxt;
  logic                        synced_r, synced_nxt;
  swft_pkg::link_state_t       mode_r, mode_nxt;
  logic [swft_pkg::CNT_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic [swft_pkg::CNT_W-1:0]  lost_cnt_r, lost_cnt_nxt;
  logic [swft_pkg::CNT_W-1:0]  perr_cnt_r, perr_cnt_nxt;

  // Per entry: which bank holds the active / next byte, and whether it reads as zero.
  logic [MAX_FRAME-1:0] act_bank_r, act_bank_nxt;
  logic [MAX_FRAME-1:0] nxt_bank_r, nxt_bank_nxt;
  logic [MAX_FRAME-1:0] act_zero_r, act_zero_nxt;
  logic [MAX_FRAME-1:0] nxt_zero_r, nxt_zero_nxt;

  logic [swft_pkg::RX_W-1:0] tx_mem [DEPTH];
  logic [swft_pkg::RX_W-1:0] mem_rd_r;

  logic                  s1_valid_r;
  logic                  s1_zero_r;
  swft_pkg::res_t        s1_res_r;
  swft_pkg::res_t        res_nxt;
  logic                  out_valid_r;
  logic [swft_pkg::RX_W-1:0] out_tx_r;
  swft_pkg::res_t        out_res_r;

  logic                  s1_adv;
  logic                  in_fire;
  logic                  is_rx;
  logic                  mem_we;
  logic [IDXW:0]         mem_waddr;
  logic [IDXW:0]         mem_raddr;
  logic                  rd_zero;

  logic [swft_pkg::CMP_W-1:0] fsz, fs, wp_ext, wp_calc, pos_calc, tx_idx, lidx_ext;
  logic [IDXW-1:0]            lidx;
  logic [IDXW-1:0]            rd_idx;
  logic                       copy;
  logic                       acc;
  logic                       fend;

  function automatic logic [swft_pkg::CNT_W-1:0] sat_inc(logic [swft_pkg::CNT_W-1:0] v);
    return (&v) ? v : v + swft_pkg::CNT_W'(1);
  endfunction

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_rx       = in_fire && (in_ch.req_type == swft_pkg::REQ_RX);
  assign cfg_ch.ready = 1'b1;

  // Clamp frame size to 2..MAX_FRAME.
  always_comb begin
    fsz = {1'b0, frame_size_r};
    if (fsz < swft_pkg::SYNC_LEN) begin
      fs = swft_pkg::SYNC_LEN;
    end else if (fsz > MAX_C) begin
      fs = MAX_C;
    end else begin
      fs = fsz;
    end
  end

  assign wp_ext   = swft_pkg::CMP_W'(wp_r);
  assign lidx_ext = swft_pkg::CMP_W'(in_ch.load_index);
  assign lidx     = lidx_ext[IDXW-1:0];

  // Frame tracking for a received byte.
  always_comb begin
    synced_nxt    = synced_r;
    mode_nxt      = mode_r;
    frame_cnt_nxt = frame_cnt_r;
    lost_cnt_nxt  = lost_cnt_r;
    perr_cnt_nxt  = perr_cnt_r;
    wp_calc       = wp_ext;
    pos_calc      = '0;
    acc           = 1'b0;
    fend          = 1'b0;
    if (!synced_r) begin
      mode_nxt = swft_pkg::LINK_SYNCING;
      if (wp_ext == 7'd0 && in_ch.rx_byte == sync_first_r) begin
        acc     = 1'b1;
        wp_calc = 7'd1;
      end else if (wp_ext == 7'd1 && in_ch.rx_byte == sync_second_r) begin
        acc        = 1'b1;
        pos_calc   = 7'd1;
        synced_nxt = 1'b1;
        wp_calc    = swft_pkg::SYNC_LEN;
        if (swft_pkg::SYNC_LEN >= fs) begin
          fend          = 1'b1;
          wp_calc       = '0;
          frame_cnt_nxt = sat_inc(frame_cnt_r);
        end
      end else begin
        lost_cnt_nxt = sat_inc(lost_cnt_r);
        wp_calc      = '0;
      end
    end else begin
      mode_nxt = swft_pkg::LINK_XCVR;
      if ((wp_ext == 7'd0 && in_ch.rx_byte != sync_first_r) ||
          (wp_ext == 7'd1 && in_ch.rx_byte != sync_second_r)) begin
        synced_nxt   = 1'b0;
        lost_cnt_nxt = sat_inc(lost_cnt_r);
        perr_cnt_nxt = sat_inc(perr_cnt_r);
        wp_calc      = '0;
      end else begin
        acc      = 1'b1;
        pos_calc = wp_ext;
        wp_calc  = wp_ext + 7'd1;
        if (wp_calc >= fs) begin
          fend          = 1'b1;
          wp_calc       = '0;
          frame_cnt_nxt = sat_inc(frame_cnt_r);
        end
      end
    end
    tx_idx = wp_calc + 7'd1;
    copy   = tx_idx >= fs;
    if (copy) begin
      tx_idx = '0;
    end
    wp_nxt = wp_calc[IDXW-1:0];

    res_nxt.accepted             = acc;
    res_nxt.byte_position        = pos_calc[swft_pkg::POS_W-1:0];
    res_nxt.data_byte            = in_ch.rx_byte;
    res_nxt.frame_end            = fend;
    res_nxt.link_state           = mode_nxt;
    res_nxt.frames_received      = frame_cnt_nxt;
    res_nxt.bytes_lost_syncing   = lost_cnt_nxt;
    res_nxt.partial_frame_errors = perr_cnt_nxt;
  end

  // Bank flags: a copy repoints active entries at the next bank, a load writes the
  // bank the active frame does not use, a clear marks every next entry zero.
  always_comb begin
    act_bank_nxt = act_bank_r;
    nxt_bank_nxt = nxt_bank_r;
    act_zero_nxt = act_zero_r;
    nxt_zero_nxt = nxt_zero_r;
    mem_we       = 1'b0;
    mem_waddr    = {~act_bank_r[lidx], lidx};
    if (in_fire) begin
      case (in_ch.req_type)
        swft_pkg::REQ_RX: begin
          if (copy) begin
            for (int i = 0; i < MAX_FRAME; i++) begin
              if (swft_pkg::CMP_W'(i) < fs) begin
                act_bank_nxt[i] = nxt_bank_r[i];
                act_zero_nxt[i] = nxt_zero_r[i];
              end
            end
          end
        end
        swft_pkg::REQ_LOAD: begin
          if (lidx_ext < fs) begin
            mem_we             = 1'b1;
            nxt_bank_nxt[lidx] = ~act_bank_r[lidx];
            nxt_zero_nxt[lidx] = 1'b0;
          end
        end
        swft_pkg::REQ_CLEAR: begin
          nxt_zero_nxt = '1;
        end
        default: begin
        end
      endcase
    end
  end

  // A copy always lands the read on entry zero, which the copy covers.
  assign rd_idx    = tx_idx[IDXW-1:0];
  assign mem_raddr = {copy ? nxt_bank_r[rd_idx] : act_bank_r[rd_idx], rd_idx};
  assign rd_zero   = copy ? nxt_zero_r[rd_idx] : act_zero_r[rd_idx];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[mem_waddr] <= in_ch.load_value;
    end
    if (is_rx) begin
      mem_rd_r <= tx_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r  <= swft_pkg::FRAME_SIZE_RST;
      sync_first_r  <= swft_pkg::SYNC_FIRST_RST;
      sync_second_r <= swft_pkg::SYNC_SECOND_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        swft_pkg::CFG_FRAME_SIZE:  frame_size_r  <= cfg_ch.data[swft_pkg::FS_W-1:0];
        swft_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_ch.data;
        swft_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      synced_r    <= 1'b0;
      mode_r      <= swft_pkg::LINK_IDLE;
      frame_cnt_r <= '0;
      lost_cnt_r  <= '0;
      perr_cnt_r  <= '0;
      act_bank_r  <= '0;
      nxt_bank_r  <= '0;
      act_zero_r  <= '1;
      nxt_zero_r  <= '1;
    end else begin
      if (is_rx) begin
        wp_r        <= wp_nxt;
        synced_r    <= synced_nxt;
        mode_r      <= mode_nxt;
        frame_cnt_r <= frame_cnt_nxt;
        lost_cnt_r  <= lost_cnt_nxt;
        perr_cnt_r  <= perr_cnt_nxt;
      end
      act_bank_r <= act_bank_nxt;
      nxt_bank_r <= nxt_bank_nxt;
      act_zero_r <= act_zero_nxt;
      nxt_zero_r <= nxt_zero_nxt;
    end
  end

  // Read stage, then output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (is_rx) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_rx) begin
      s1_res_r  <= res_nxt;
      s1_zero_r <= rd_zero;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= s1_res_r;
      out_tx_r  <= s1_zero_r ? '0 : mem_rd_r;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.tx_byte              = out_tx_r;
  assign out_ch.accepted             = out_res_r.accepted;
  assign out_ch.byte_position        = out_res_r.byte_position;
  assign out_ch.data_byte            = out_res_r.data_byte;
  assign out_ch.frame_end            = out_res_r.frame_end;
  assign out_ch.link_state           = out_res_r.link_state;
  assign out_ch.frames_received      = out_res_r.frames_received;
  assign out_ch.bytes_lost_syncing   = out_res_r.bytes_lost_syncing;
  assign out_ch.partial_frame_errors = out_res_r.partial_frame_errors;

endmodule

// File: design/swft_checker.sv
`include "assert_macros.svh"

module swft_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [swft_pkg::RX_W-1:0]  out_tx_byte,
  input logic                       out_accepted,
  input logic [swft_pkg::POS_W-1:0] out_byte_position,
  input logic                       out_frame_end,
  input logic [1:0]                 out_link_state
);

  `AST_ALL(a_rst_clears_out, !rst_n |=> !out_valid, "result valid right after reset")
  `AST_ON(a_fend_needs_acc, out_valid && out_frame_end |-> out_accepted, "frame end on dropped byte")
  `AST_ON(a_drop_pos_zero, out_valid && !out_accepted |-> out_byte_position == 5'd0, "dropped byte has a position")
  `AST_ON(a_hunt_pos, out_valid && out_accepted && out_link_state == swft_pkg::LINK_SYNCING |-> out_byte_position <= 5'd1, "hunt accepted beyond sync bytes")
  `AST_ON(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_tx_byte), "stalled result changed")

endmodule

bind sync_word_frame_transceiver swft_checker u_swft_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_tx_byte       (out_ch.tx_byte),
  .out_accepted      (out_ch.accepted),
  .out_byte_position (out_ch.byte_position),
  .out_frame_end     (out_ch.frame_end),
  .out_link_state    (out_ch.link_state)
);
